>>> rtl/laplacian_sharpen_3x3_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 sharpening block.
// Each macro expects clk and rst_n in scope; checks are off while in reset.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_SHARPEN_3X3_ASSERT_SVH
`define LAPLACIAN_SHARPEN_3X3_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define LSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define LSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, register codes and interface types of the 3x3
// sharpening block.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

  // Frame limits
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_CHANNELS = 4;
  localparam int MIN_WIDTH    = 3;
  localparam int MIN_HEIGHT   = 3;
  localparam int MIN_CHANNELS = 1;

  // Register reset values
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int RESET_CHANNELS = 3;

  // Field and store widths
  localparam int SAMPLE_W    = 8;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 13;
  localparam int CHAN_W      = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_LEN_W   = ADDR_W + 1;
  localparam int ROW_W       = $clog2(MAX_HEIGHT);

  // Sliding window over the previous row: two pixels of channels plus one
  localparam int WIN_TAPS = 2 * MAX_CHANNELS + 1;
  localparam int TAP_W    = $clog2(WIN_TAPS);

  // Centre weight of the stencil
  localparam int CENTRE_GAIN = 5;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_t;

  // Frame geometry derived from the registers
  typedef struct packed {
    logic [CHAN_W-1:0]    chans;
    logic [ROW_LEN_W-1:0] row_len;
    logic [ADDR_W-1:0]    last_sample;
    logic [ADDR_W-1:0]    tail_start;
    logic [ROW_W-1:0]     last_row;
  } lss_geom_t;

  // Line store access for one sample
  typedef struct packed {
    logic                rd_en;
    logic [ADDR_W-1:0]   prior_rd_addr;
    logic [ADDR_W-1:0]   older_rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_sample;
  } lss_mem_req_t;

  // Neighbors of the sample held in the input stage
  typedef struct packed {
    logic [SAMPLE_W-1:0] centre;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] up;
  } lss_taps_t;

endpackage

`default_nettype wire

>>> rtl/lss_cfg.sv
// ----------------------------------------------------------------------------
// lss_cfg
// Configuration registers: clamps each write to its legal range and keeps
// the derived frame geometry ready for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_cfg
  import lss_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output lss_geom_t                   geom,
  output logic                        restart
);

  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [CHAN_W-1:0]   chans_r, chans_nxt;
  lss_geom_t           geom_r, geom_nxt;
  logic [WIDTH_W-1:0]  wr_width;
  logic [HEIGHT_W-1:0] wr_height;
  logic [CHAN_W-1:0]   wr_chans;
  logic [2*ROW_LEN_W-1:0] row_len_full;
  logic [2*ROW_LEN_W-1:0] tail_full;

  // Clamp the written value of each register
  always_comb begin
    wr_width  = cfg_data[WIDTH_W-1:0];
    wr_height = cfg_data[HEIGHT_W-1:0];
    wr_chans  = cfg_data[CHAN_W-1:0];
    if (wr_width < WIDTH_W'(MIN_WIDTH)) begin
      wr_width = WIDTH_W'(MIN_WIDTH);
    end else if (wr_width > WIDTH_W'(MAX_WIDTH)) begin
      wr_width = WIDTH_W'(MAX_WIDTH);
    end
    if (wr_height < HEIGHT_W'(MIN_HEIGHT)) begin
      wr_height = HEIGHT_W'(MIN_HEIGHT);
    end else if (wr_height > HEIGHT_W'(MAX_HEIGHT)) begin
      wr_height = HEIGHT_W'(MAX_HEIGHT);
    end
    if (wr_chans < CHAN_W'(MIN_CHANNELS)) begin
      wr_chans = CHAN_W'(MIN_CHANNELS);
    end else if (wr_chans > CHAN_W'(MAX_CHANNELS)) begin
      wr_chans = CHAN_W'(MAX_CHANNELS);
    end
  end

  // Select the register that a write targets
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    chans_nxt  = chans_r;
    restart    = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          width_nxt = wr_width;
          restart   = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          height_nxt = wr_height;
          restart    = 1'b1;
        end
        CFG_CHANNEL_COUNT: begin
          chans_nxt = wr_chans;
          restart   = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // Derive row geometry from the next register values
  always_comb begin
    row_len_full = ROW_LEN_W'(width_nxt) * ROW_LEN_W'(chans_nxt);
    tail_full    = ROW_LEN_W'(width_nxt - WIDTH_W'(1)) * ROW_LEN_W'(chans_nxt);
    geom_nxt.chans       = chans_nxt;
    geom_nxt.row_len     = row_len_full[ROW_LEN_W-1:0];
    geom_nxt.last_sample = ADDR_W'(row_len_full[ROW_LEN_W-1:0] - ROW_LEN_W'(1));
    geom_nxt.tail_start  = tail_full[ADDR_W-1:0];
    geom_nxt.last_row    = ROW_W'(height_nxt - HEIGHT_W'(1));
  end

  // Hold registers and geometry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r             <= WIDTH_W'(RESET_WIDTH);
      height_r            <= HEIGHT_W'(RESET_HEIGHT);
      chans_r             <= CHAN_W'(RESET_CHANNELS);
      geom_r.chans        <= CHAN_W'(RESET_CHANNELS);
      geom_r.row_len      <= ROW_LEN_W'(RESET_WIDTH * RESET_CHANNELS);
      geom_r.last_sample  <= ADDR_W'(RESET_WIDTH * RESET_CHANNELS - 1);
      geom_r.tail_start   <= ADDR_W'((RESET_WIDTH - 1) * RESET_CHANNELS);
      geom_r.last_row     <= ROW_W'(RESET_HEIGHT - 1);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      chans_r  <= chans_nxt;
      geom_r   <= geom_nxt;
    end
  end

  assign geom = geom_r;

endmodule

`default_nettype wire

>>> rtl/lss_lines.sv
// ----------------------------------------------------------------------------
// lss_lines
// Two line stores (previous row and the row before it) and a sliding
// window over the previous row, read one channel group ahead of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_lines
  import lss_pkg::*;
(
  input  wire logic              clk,
  input  wire lss_mem_req_t      req,
  input  wire logic [CHAN_W-1:0] chans,
  output lss_taps_t              taps
);

  logic [SAMPLE_W-1:0] prior_mem [STORE_DEPTH];
  logic [SAMPLE_W-1:0] older_mem [STORE_DEPTH];
  logic [SAMPLE_W-1:0] prior_rd_r;
  logic [SAMPLE_W-1:0] older_rd_r;
  logic [SAMPLE_W-1:0] win_r [1:WIN_TAPS-1];
  logic [SAMPLE_W-1:0] tap [WIN_TAPS];
  logic [TAP_W-1:0]    centre_sel;
  logic [TAP_W-1:0]    left_sel;

  // Read both stores on a transfer; shift the previous-row window
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      prior_rd_r <= prior_mem[req.prior_rd_addr];
      older_rd_r <= older_mem[req.older_rd_addr];
      win_r[1]   <= prior_rd_r;
      for (int k = 2; k < WIN_TAPS; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  // Retire a sample: age the previous row, store the new sample
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      older_mem[req.wr_addr] <= tap[centre_sel];
      prior_mem[req.wr_addr] <= req.wr_sample;
    end
  end

  // Tap zero is the newest read, one channel group right of the centre
  always_comb begin
    tap[0] = prior_rd_r;
    for (int k = 1; k < WIN_TAPS; k++) begin
      tap[k] = win_r[k];
    end
    centre_sel  = TAP_W'(chans);
    left_sel    = TAP_W'({chans, 1'b0});
    taps.right  = tap[0];
    taps.centre = tap[centre_sel];
    taps.left   = tap[left_sel];
    taps.up     = older_rd_r;
  end

endmodule

`default_nettype wire

>>> rtl/laplacian_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// Streaming 3x3 sharpening stencil (5 x centre minus four neighbors) on
// interleaved 8-bit channel samples, clamped to 0..255, one row of latency.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in_       input      in_valid/in_ready    in_sample
//   out_      output     out_valid/out_ready  out_sample, out_end_of_row,
//                                             out_end_of_frame
//   cfg_      input      cfg_we               cfg_index, cfg_data
//
// One sample per clock sustained while the output is not stalled; each
// input transfer reads the line stores into the input stage, and the
// stencil enters the result register when that stage retires. The
// registered read of each line store sets that rate.
// Reset clears positions, handshake state and registers; the line stores
// are not cleared. A stalled result keeps the input stage full while the
// next sample is still taken if the stage can retire.
// Input row 0 produces no results; the bottom border row is not sent.
// ----------------------------------------------------------------------------
`default_nettype none

`include "laplacian_sharpen_3x3_assert.svh"

module laplacian_sharpen_3x3
  import lss_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_W-1:0]    in_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SAMPLE_W-1:0]         out_sample,
  output logic                        out_end_of_row,
  output logic                        out_end_of_frame,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  lss_geom_t    geom;
  logic         restart;
  lss_mem_req_t mem_req;
  lss_taps_t    taps;

  logic in_xfer;
  logic s1_adv;
  logic out_load;

  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [ADDR_W-1:0]   s1_col_r;
  logic                s1_emit_r;
  logic                s1_border_r;
  logic                s1_eor_r;
  logic                s1_eof_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_eor_r;
  logic                out_eof_r;

  logic [ROW_LEN_W-1:0] ahead_sum;
  logic [ADDR_W-1:0]    ahead_addr;
  logic                 at_last_sample;
  logic                 border_now;

  logic [SAMPLE_W+2:0]  pos_term;
  logic [SAMPLE_W+1:0]  neg_term;
  logic [SAMPLE_W+2:0]  diff;
  logic [SAMPLE_W-1:0]  sharp;

  lss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .restart   (restart)
  );

  // Handshake: the input stage retires when its result has room or it makes no result
  assign s1_adv   = s1_valid_r && (!s1_emit_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;
  assign out_load = s1_adv && s1_emit_r;

  // Position flags and the look-ahead address of the right neighbor
  always_comb begin
    at_last_sample = (col_r == geom.last_sample);
    border_now     = (row_r == ROW_W'(1)) || (col_r < ADDR_W'(geom.chans)) ||
                     (col_r >= geom.tail_start);
    ahead_sum      = ROW_LEN_W'(col_r) + ROW_LEN_W'(geom.chans);
    if (ahead_sum >= geom.row_len) begin
      ahead_addr = ADDR_W'(ahead_sum - geom.row_len);
    end else begin
      ahead_addr = ADDR_W'(ahead_sum);
    end
  end

  // Advance column and row on each input transfer; a config write restarts both at zero
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_xfer) begin
      if (at_last_sample) begin
        col_nxt = '0;
        row_nxt = (row_r == geom.last_row) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + ADDR_W'(1);
      end
    end
  end

  // Line store access
  always_comb begin
    mem_req.rd_en         = in_xfer;
    mem_req.prior_rd_addr = ahead_addr;
    mem_req.older_rd_addr = col_r;
    mem_req.wr_en         = s1_adv;
    mem_req.wr_addr       = s1_col_r;
    mem_req.wr_sample     = s1_sample_r;
  end

  lss_lines u_lines (
    .clk   (clk),
    .req   (mem_req),
    .chans (geom.chans),
    .taps  (taps)
  );

  // Stencil: 5 x centre minus the four neighbors, clamped to 0..255; border results are zero
  always_comb begin
    pos_term = (SAMPLE_W+3)'(taps.centre) * (SAMPLE_W+3)'(CENTRE_GAIN);
    neg_term = (SAMPLE_W+2)'(taps.left) + (SAMPLE_W+2)'(taps.right) +
               (SAMPLE_W+2)'(taps.up) + (SAMPLE_W+2)'(s1_sample_r);
    diff     = pos_term - (SAMPLE_W+3)'(neg_term);
    if (s1_border_r || ((SAMPLE_W+3)'(neg_term) >= pos_term)) begin
      sharp = '0;
    end else if (diff > (SAMPLE_W+3)'({SAMPLE_W{1'b1}})) begin
      sharp = '1;
    end else begin
      sharp = diff[SAMPLE_W-1:0];
    end
  end

  // Control state: positions and stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the input sample and its position flags
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_sample;
      s1_col_r    <= col_r;
      s1_emit_r   <= (row_r != '0);
      s1_border_r <= border_now;
      s1_eor_r    <= at_last_sample;
      s1_eof_r    <= at_last_sample && (row_r == geom.last_row);
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= sharp;
      out_eor_r    <= s1_eor_r;
      out_eof_r    <= s1_eof_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  // Checks
  `LSS_ASSERT_NOW(a_eof_on_eor, out_valid_r && out_eof_r, out_eor_r, "frame end without row end")
  `LSS_ASSERT_NEXT(a_border_zero, out_load && s1_border_r, out_sample_r == '0, "border not zero")
  `LSS_ASSERT_NOW(a_col_range, 1'b1, col_r <= geom.last_sample, "column past row end")
  `LSS_ASSERT_NOW(a_row_range, 1'b1, row_r <= geom.last_row, "row past frame end")
  `LSS_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_col_r), "stage lost")

endmodule

`default_nettype wire
